/* design/ptwbp_pkg.sv */
// Shared types, constants and helpers for the per-type window byte policer.
package ptwbp_pkg;

  localparam int unsigned IN_DATA_W  = 56;
  localparam int unsigned OUT_DATA_W = 120;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned DIV_STEPS  = 48;
  localparam int unsigned DIV_CNT_W  = 6;

  localparam logic [0:0]  REG_BUDGET   = 1'b0;
  localparam logic [0:0]  REG_OVERHEAD = 1'b1;

  localparam logic [31:0] BUDGET_RST   = 32'd2048;
  localparam logic [7:0]  OVERHEAD_RST = 8'd12;
  localparam logic [31:0] SAT_MAX      = 32'hFFFF_FFFF;

  localparam logic REQ_MSG    = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  typedef struct packed {
    logic [31:0] bytes;
    logic [31:0] tag;
    logic [31:0] acc_cnt;
    logic [31:0] sec_cnt;
    logic        last_vld;
    logic [31:0] last_sec;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic calc;
    logic update;
    logic rpt_load;
    logic div_start;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_rpt;
    logic div_needed;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == SAT_MAX) ? v : v + 32'd1;
  endfunction

endpackage

/* design/ptwbp_div.sv */
// Restoring divider, one quotient bit per cycle, 48-bit dividend by 32-bit divisor.
module ptwbp_div
  import ptwbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [47:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [47:0]          quo_r, quo_nxt;
  logic [31:0]          dvs_r, dvs_nxt;
  logic [32:0]          trial;
  logic                 ge;

  assign trial = {rem_r, quo_r[47]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? 32'(trial - {1'b0, dvs_r}) : trial[31:0];
      quo_nxt = {quo_r[46:0], ge};
      cnt_nxt = cnt_r + DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* design/ptwbp_dp.sv */
// Datapath: per-type table, byte window math, counters, divider and output register.
module ptwbp_dp
  import ptwbp_pkg::*;
#(
  parameter int unsigned TYPE_COUNT = 256
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic                  in_req,
  input  logic [IN_DATA_W-1:0]  in_data,
  input  logic                  cfg_wr_en,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  localparam int unsigned DEPTH = (TYPE_COUNT < 256) ? TYPE_COUNT : 256;
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [IDX_W-1:0] mod_tbl [256];

  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tbl[g] = IDX_W'(g % TYPE_COUNT);
  end

  entry_t           mem [DEPTH];
  entry_t           ent_r;
  entry_t           wr_ent;
  logic [DEPTH-1:0] seen_r;

  logic [31:0]      budget_r;
  logic [7:0]       ovh_r;
  logic [31:0]      cur_r;
  logic             req_r;
  logic [31:0]      time_r;
  logic [15:0]      len_r;
  logic [IDX_W-1:0] idx_r;
  logic [31:0]      sum_r;

  logic             res_accepted_r;
  logic             res_present_r;
  logic [31:0]      res_acc_r;
  logic [31:0]      res_sec_r;
  logic [47:0]      res_avg_r;

  logic             out_valid_r;
  logic             o_accepted_r;
  logic             o_present_r;
  logic [31:0]      o_acc_r;
  logic [31:0]      o_sec_r;
  logic [47:0]      o_avg_r;

  logic [31:0]      in_time;
  logic [7:0]       in_type;
  logic [15:0]      in_len;
  logic             seen_b;
  logic [31:0]      eff_bytes;
  logic [32:0]      sum_wide;
  logic             ok;
  logic [31:0]      base_acc;
  logic [31:0]      base_sec;
  logic             base_lv;
  logic             later;
  logic             div_done;
  logic [47:0]      div_q;

  assign in_time = in_data[31:0];
  assign in_type = in_data[39:32];
  assign in_len  = in_data[55:40];
  assign seen_b  = seen_r[idx_r];

  // window restarts when the stored tag is stale
  assign eff_bytes = (seen_b && ent_r.tag == cur_r) ? ent_r.bytes : 32'd0;
  assign sum_wide  = {1'b0, eff_bytes} + 33'(len_r) + 33'(ovh_r);

  assign ok       = sum_r < budget_r;
  assign base_acc = seen_b ? ent_r.acc_cnt : 32'd0;
  assign base_sec = seen_b ? ent_r.sec_cnt : 32'd0;
  assign base_lv  = seen_b && ent_r.last_vld;
  assign later    = !base_lv || (time_r > ent_r.last_sec);

  always_comb begin
    wr_ent.bytes    = sum_r;
    wr_ent.tag      = cur_r;
    wr_ent.acc_cnt  = ok ? sat_inc(base_acc) : base_acc;
    wr_ent.sec_cnt  = (ok && later) ? sat_inc(base_sec) : base_sec;
    wr_ent.last_vld = base_lv || (ok && later);
    wr_ent.last_sec = (ok && later) ? time_r : ent_r.last_sec;
  end

  ptwbp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({ent_r.acc_cnt, 16'd0}),
    .divisor  (ent_r.sec_cnt),
    .done     (div_done),
    .quotient (div_q)
  );

  assign status.is_rpt     = req_r;
  assign status.div_needed = seen_b && (ent_r.sec_cnt != 32'd0);
  assign status.div_done   = div_done;
  assign status.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ent_r <= mem[mod_tbl[in_type]];
    end
    if (cmd.update) begin
      mem[idx_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= BUDGET_RST;
      ovh_r       <= OVERHEAD_RST;
      cur_r       <= '0;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_BUDGET:   budget_r <= cfg_wdata;
          REG_OVERHEAD: ovh_r    <= cfg_wdata[7:0];
          default:      ;
        endcase
      end
      if (cmd.capture && in_req == REQ_MSG && in_time > cur_r) begin
        cur_r <= in_time;
      end
      if (cmd.update) begin
        seen_r[idx_r] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_req;
      time_r <= in_time;
      len_r  <= in_len;
      idx_r  <= mod_tbl[in_type];
    end
    if (cmd.calc) begin
      sum_r <= sum_wide[32] ? SAT_MAX : sum_wide[31:0];
    end
    if (cmd.update) begin
      res_accepted_r <= ok;
      res_present_r  <= 1'b1;
      res_acc_r      <= wr_ent.acc_cnt;
      res_sec_r      <= wr_ent.sec_cnt;
      res_avg_r      <= '0;
    end
    if (cmd.rpt_load) begin
      res_accepted_r <= 1'b0;
      res_present_r  <= seen_b;
      res_acc_r      <= base_acc;
      res_sec_r      <= base_sec;
      res_avg_r      <= '0;
    end
    if (div_done) begin
      res_avg_r <= div_q;
    end
    if (cmd.out_load) begin
      o_accepted_r <= res_accepted_r;
      o_present_r  <= res_present_r;
      o_acc_r      <= res_acc_r;
      o_sec_r      <= res_sec_r;
      o_avg_r      <= res_avg_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = {6'd0, o_avg_r, o_sec_r, o_acc_r, o_present_r, o_accepted_r};

endmodule

/* design/ptwbp_ctrl.sv */
// Controller: sequences read, compute, table write, divide and result hand-off.
module ptwbp_ctrl
  import ptwbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_UPD  = 5'b00100,
    S_DIV  = 5'b01000,
    S_HOLD = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        if (!status.is_rpt) begin
          cmd.calc  = 1'b1;
          state_nxt = S_UPD;
        end else begin
          cmd.rpt_load = 1'b1;
          if (status.div_needed) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end else begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_HOLD;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* design/per_type_window_byte_policer.sv */
// Top level of the per-type window byte policer.
//
//   port group  dir  word contents (lowest bit first)
//   in_*        in   tuser: req_type; tdata: msg_time, msg_type, payload_len
//   out_*       out  tdata: accepted, type_present, accepted_total,
//                    active_seconds, average_rate
//   cfg_*       in   index 0 window_byte_budget, 1 header_overhead
//
// A message runs table read, byte sum, table write, result load; a report runs
// table read, result load and, when its type has active seconds, the bit-serial
// divider, one quotient bit per cycle, before output load. Reset is synchronous;
// it clears the seen flags, the current time and output valid and reloads config
// defaults. A word waits in the output register while the next one is taken.
module per_type_window_byte_policer
  import ptwbp_pkg::*;
#(
  parameter int unsigned TYPE_COUNT = 256
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // msg_time, msg_type, payload_len
  input  logic                  in_tuser,   // req_type
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // accepted, type_present, accepted_total,
                                            // active_seconds, average_rate, pad
  input  logic                  cfg_wr_en,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t    cmd;
  dp_status_t status;

  ptwbp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ptwbp_dp #(
    .TYPE_COUNT (TYPE_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_req    (in_tuser),
    .in_data   (in_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

/* verif/tb.sv */
// Self-checking testbench for the per-type window byte policer stream block.
`timescale 1ns / 1ps

module tb;
  import ptwbp_pkg::*;

  typedef struct {
    logic        req;
    logic [31:0] t;
    logic [7:0]  mtype;
    logic [15:0] len;
  } policer_req_t;

  typedef struct {
    logic        accepted;
    logic        present;
    logic [31:0] acc_total;
    logic [31:0] act_sec;
    logic [47:0] avg_rate;
  } policer_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [0:0]            cfg_index = REG_BUDGET;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  per_type_window_byte_policer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // policer state mirror
  logic [31:0] budget_r   = BUDGET_RST;
  logic [7:0]  overhead_r = OVERHEAD_RST;
  logic [31:0] now_sec    = '0;
  logic        seen     [256];
  logic [31:0] win_bytes[256];
  logic [31:0] win_tag  [256];
  logic [31:0] acc_cnt  [256];
  logic [31:0] sec_cnt  [256];
  longint      last_sec [256];

  policer_req_t    msg_queue[$];
  policer_result_t expected_words[$];
  int unsigned     words_queued = 0;
  int unsigned     words_sent = 0;
  int unsigned     fail_cnt = 0;
  int unsigned     cyc = 0;
  logic            in_taken = 1'b0;
  logic [31:0]     gen_time = '0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  initial begin
    foreach (seen[i]) seen[i] = 1'b0;
  end

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic policer_result_t policer_predict(input policer_req_t r);
    policer_result_t res;
    logic [7:0]      k;
    logic [32:0]     sum;
    logic [47:0]     num;
    res = '{default: '0};
    k = r.mtype;
    if (r.req == REQ_MSG) begin
      if (r.t > now_sec) now_sec = r.t;
      if (!seen[k]) begin
        seen[k] = 1'b1;
        win_bytes[k] = '0;
        win_tag[k] = now_sec;
        acc_cnt[k] = '0;
        sec_cnt[k] = '0;
        last_sec[k] = -1;
      end
      if (win_tag[k] != now_sec) begin
        win_bytes[k] = '0;
        win_tag[k] = now_sec;
      end
      sum = {1'b0, win_bytes[k]} + {17'b0, r.len} + {25'b0, overhead_r};
      win_bytes[k] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      if (win_bytes[k] < budget_r) begin
        res.accepted = 1'b1;
        acc_cnt[k] = bump(acc_cnt[k]);
        if (longint'({32'b0, r.t}) > last_sec[k]) begin
          last_sec[k] = longint'({32'b0, r.t});
          sec_cnt[k] = bump(sec_cnt[k]);
        end
      end
    end else if (seen[k] && sec_cnt[k] != 0) begin
      num = {acc_cnt[k], 16'h0000};
      res.avg_rate = num / {16'b0, sec_cnt[k]};
    end
    if (seen[k]) begin
      res.present = 1'b1;
      res.acc_total = acc_cnt[k];
      res.act_sec = sec_cnt[k];
    end
    return res;
  endfunction

  function automatic logic quiet();
    return cyc >= 3000 && cyc < 6000;
  endfunction

  always @(posedge clk) cyc <= cyc + 1;

  // input driver
  always @(negedge clk) begin
    policer_req_t nxt;
    logic         go;
    if (rst_n && (!in_tvalid || in_taken)) begin
      go = msg_queue.size() > 0 && !(!quiet() && $urandom_range(99) < 6);
      if (go) begin
        nxt = msg_queue.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {nxt.len, nxt.mtype, nxt.t};
        in_tuser <= nxt.req;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) out_tready <= quiet() || $urandom_range(99) >= 6;
  end

  task automatic check_field(input string name, input logic [47:0] exp_v,
                             input logic [47:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s: expected %h actual %h", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  // monitor: predict on input words, check output words
  always @(posedge clk) begin
    policer_req_t    r;
    policer_result_t e;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      r.t = in_tdata[31:0];
      r.mtype = in_tdata[39:32];
      r.len = in_tdata[55:40];
      r.req = in_tuser;
      expected_words.push_back(policer_predict(r));
      words_sent++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $display("%0t unexpected word: expected none actual %h", $time, out_tdata);
        fail_cnt++;
      end else begin
        e = expected_words.pop_front();
        check_field("accepted", 48'(e.accepted), 48'(out_tdata[0]));
        check_field("type_present", 48'(e.present), 48'(out_tdata[1]));
        check_field("accepted_total", 48'(e.acc_total), 48'(out_tdata[33:2]));
        check_field("active_seconds", 48'(e.act_sec), 48'(out_tdata[65:34]));
        check_field("average_rate", e.avg_rate, out_tdata[113:66]);
      end
    end
  end

  task automatic add_item(input logic req, input logic [31:0] t, input logic [7:0] mtype,
                          input logic [15:0] len);
    policer_req_t r;
    r.req = req;
    r.t = t;
    r.mtype = mtype;
    r.len = len;
    msg_queue.push_back(r);
    words_queued++;
  endtask

  task automatic queue_random(input int n, input int unsigned max_len);
    logic [31:0] t;
    logic [7:0]  mtype;
    logic [15:0] len;
    int unsigned sel;
    for (int i = 0; i < n; i++) begin
      mtype = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      len = ($urandom_range(99) < 90) ? 16'($urandom_range(0, max_len)) : 16'($urandom);
      if ($urandom_range(99) < 10) begin
        add_item(REQ_REPORT, $urandom, mtype, 16'($urandom));
      end else begin
        sel = $urandom_range(99);
        if (gen_time < 32'hFFFF_FF00) begin
          if (sel < 60) gen_time += $urandom_range(0, 1);
          else if (sel < 80) gen_time += $urandom_range(2, 4);
        end
        if (sel < 80) t = gen_time;
        else if (sel < 92) t = gen_time - ((gen_time < 8) ? gen_time : $urandom_range(0, 8));
        else t = $urandom_range(0, gen_time);
        add_item(REQ_MSG, t, mtype, len);
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (msg_queue.size() != 0 || words_sent != words_queued ||
           expected_words.size() != 0);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    if (idx == REG_BUDGET) budget_r = val;
    else overhead_r = val[7:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // defaults: unseen report, window edges, late timestamp
    add_item(REQ_REPORT, 32'd0, 8'd0, 16'd0);
    add_item(REQ_MSG, 32'd0, 8'd0, 16'd0);
    add_item(REQ_MSG, 32'd0, 8'd255, 16'hFFFF);
    add_item(REQ_MSG, 32'd5, 8'd0, 16'd2000);
    add_item(REQ_MSG, 32'd5, 8'd0, 16'd100);
    add_item(REQ_MSG, 32'd3, 8'd0, 16'd10);
    add_item(REQ_MSG, 32'd6, 8'd0, 16'd0);
    add_item(REQ_REPORT, 32'd0, 8'd0, 16'd0);
    add_item(REQ_REPORT, 32'hFFFF_FFFF, 8'd255, 16'hFFFF);
    add_item(REQ_REPORT, 32'd0, 8'd128, 16'd0);
    add_item(REQ_MSG, 32'd6, 8'd1, 16'd2035);
    add_item(REQ_MSG, 32'd6, 8'd2, 16'd2036);
    add_item(REQ_MSG, 32'd7, 8'd1, 16'd1);
    add_item(REQ_REPORT, 32'd0, 8'd1, 16'd0);
    gen_time = 32'd7;
    queue_random(400, 700);
    wait_drained();
    queue_random(150, 700);
    wait_drained();

    write_reg(REG_BUDGET, 32'hFFFF_FFFF);
    write_reg(REG_OVERHEAD, 32'h0000_00FF);
    add_item(REQ_MSG, gen_time, 8'd9, 16'hFFFF);
    queue_random(200, 65535);
    wait_drained();

    write_reg(REG_BUDGET, 32'd1);
    write_reg(REG_OVERHEAD, 32'd0);
    gen_time += 1;
    add_item(REQ_MSG, gen_time, 8'd10, 16'd0);
    add_item(REQ_MSG, gen_time, 8'd10, 16'd0);
    add_item(REQ_MSG, gen_time, 8'd10, 16'd1);
    queue_random(120, 2);
    wait_drained();

    write_reg(REG_BUDGET, 32'd0);
    add_item(REQ_MSG, gen_time, 8'd11, 16'd0);
    queue_random(80, 100);
    wait_drained();

    write_reg(REG_BUDGET, $urandom_range(200, 5000));
    write_reg(REG_OVERHEAD, $urandom_range(0, 255));
    gen_time = 32'h8000_0000 + $urandom_range(0, 32'h3FFF_FFFF);
    queue_random(500, 1200);
    wait_drained();

    write_reg(REG_BUDGET, BUDGET_RST);
    write_reg(REG_OVERHEAD, OVERHEAD_RST);
    add_item(REQ_MSG, 32'hFFFF_FFFF, 8'd3, 16'd0);
    add_item(REQ_MSG, 32'd0, 8'd3, 16'd5);
    add_item(REQ_MSG, 32'hFFFF_FFFF, 8'd200, 16'd0);
    add_item(REQ_REPORT, 32'd0, 8'd3, 16'd0);
    wait_drained();

    repeat (60) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("per_type_window_byte_policer: match");
    end else begin
      $display("per_type_window_byte_policer: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("per_type_window_byte_policer: mismatch");
    $finish;
  end

endmodule
